>>> hdl/hashed_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// Hashed key-value table: assertion macros
// Shared property wrappers, clocked on clk and quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_VALUE_TABLE_DEFINES_SVH
`define HASHED_KEY_VALUE_TABLE_DEFINES_SVH

// Check an implication or plain property on every clock edge out of reset.
`define HKV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define HKV_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hdl/hkv_pkg.sv
// ----------------------------------------------------------------------------
// Hashed key-value table package
// Field widths, operation codes, controller states and the row-update result.
// ----------------------------------------------------------------------------
package hkv_pkg;

	localparam int KEY_W   = 64;
	localparam int VAL_W   = 64;
	localparam int FUNC_W  = 2;
	localparam int TOTAL_W = 11;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'h7FF;

	localparam int DEF_BUCKETS = 256;
	localparam int DEF_WAYS    = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_FIND = 2'd0,
		FUNC_ADD  = 2'd1,
		FUNC_DEL  = 2'd2,
		FUNC_RSVD = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_EXEC
	} state_t;

	// Outcome of one bucket update
	typedef struct packed {
		logic found;
		logic done;
		logic full;
		logic kwe;
		logic vwe;
		logic inc;
		logic dec;
	} res_t;

endpackage

>>> hdl/hkv_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module hkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/hkv_bucket.sv
// ----------------------------------------------------------------------------
// Bucket index unit
// Key modulo the bucket count: a mask for a power of two, else four 16-bit
// key digits, most significant first, each reduced by a registered
// reciprocal multiply followed by a multiply-subtract.
// ----------------------------------------------------------------------------
module hkv_bucket #(
	parameter int BUCKETS = hkv_pkg::DEF_BUCKETS
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [hkv_pkg::KEY_W-1:0]                   key,
	output logic                                        done,
	output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);

	import hkv_pkg::*;

	localparam int  BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam bit  POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			assign done = start;
			if (BUCKETS == 1) begin : g_one
				assign bucket = '0;
			end else begin : g_bits
				assign bucket = key[BKT_W-1:0];
			end
		end else begin : g_serial
			// floor(x / BUCKETS) == (x * MUL) >> SH_W for every 32-bit x
			localparam int          SH_W  = 32 + BKT_W;
			localparam logic [63:0] MUL   =
				((64'd1 << SH_W) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
			localparam logic [32:0] MUL_K = MUL[32:0];

			logic [KEY_W-1:0] sh_q;
			logic [BKT_W-1:0] rem_q;
			logic [64:0]      prod_q;
			logic [31:0]      dig_x;
			logic [15:0]      quo;
			logic [31:0]      part;
			logic [1:0]       cnt_q;
			logic             half_q;
			logic             busy_q;
			logic             done_q;

			// partial dividend: remainder so far, then the next key digit
			assign dig_x = (32'(rem_q) << 16) | 32'(sh_q[KEY_W-1 -: 16]);
			assign quo   = prod_q[SH_W +: 16];
			assign part  = dig_x - 32'(quo) * 32'(BUCKETS);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					cnt_q  <= '0;
					half_q <= 1'b0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						cnt_q  <= '0;
						half_q <= 1'b0;
					end else if (busy_q) begin
						half_q <= !half_q;
						if (half_q) begin
							cnt_q <= cnt_q + 2'd1;
							if (cnt_q == 2'd3) begin
								busy_q <= 1'b0;
								done_q <= 1'b1;
							end
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					sh_q  <= key;
					rem_q <= '0;
				end else if (busy_q) begin
					if (!half_q) begin
						prod_q <= 65'(dig_x) * 65'(MUL_K);
					end else begin
						sh_q  <= {sh_q[KEY_W-17:0], 16'd0};
						rem_q <= part[BKT_W-1:0];
					end
				end
			end

			assign done   = done_q;
			assign bucket = rem_q;
		end
	endgenerate

endmodule

>>> hdl/hkv_exec.sv
// ----------------------------------------------------------------------------
// Bucket row update
// Compare all ways of one row, pick hit and free ways, build the new rows.
// ----------------------------------------------------------------------------
module hkv_exec #(
	parameter int WAYS = hkv_pkg::DEF_WAYS
) (
	input  hkv_pkg::func_t                       func,
	input  logic [hkv_pkg::KEY_W-1:0]            key,
	input  logic [hkv_pkg::VAL_W-1:0]            value,
	input  logic [WAYS*(hkv_pkg::KEY_W+1)-1:0]   krow,
	input  logic [WAYS*hkv_pkg::VAL_W-1:0]       vrow,
	output logic [WAYS*(hkv_pkg::KEY_W+1)-1:0]   krow_new,
	output logic [WAYS*hkv_pkg::VAL_W-1:0]       vrow_new,
	output logic [hkv_pkg::VAL_W-1:0]            value_out,
	output hkv_pkg::res_t                        res
);

	import hkv_pkg::*;

	localparam int KE    = KEY_W + 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic             hit;
	logic             has_free;
	logic [WAY_W-1:0] hit_idx;
	logic [WAY_W-1:0] free_idx;
	logic             ins;
	logic             upd;
	logic             del;

	// Lowest matching way and lowest free way
	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (krow[w*KE + KEY_W]) begin
				if (krow[w*KE +: KEY_W] == key) begin
					hit     = 1'b1;
					hit_idx = WAY_W'(w);
				end
			end else begin
				has_free = 1'b1;
				free_idx = WAY_W'(w);
			end
		end
	end

	always_comb begin
		res       = '0;
		res.found = hit;
		ins       = 1'b0;
		upd       = 1'b0;
		del       = 1'b0;
		value_out = '0;
		unique case (func)
			FUNC_ADD: begin
				upd      = hit;
				ins      = !hit && has_free;
				res.full = !hit && !has_free;
			end
			FUNC_DEL: begin
				del = hit;
			end
			FUNC_FIND, FUNC_RSVD: begin
				for (int w = 0; w < WAYS; w++) begin
					if (hit && hit_idx == WAY_W'(w)) begin
						value_out = vrow[w*VAL_W +: VAL_W];
					end
				end
			end
		endcase
		res.done = ins || del;
		res.kwe  = ins || del;
		res.vwe  = ins || upd;
		res.inc  = ins;
		res.dec  = del;
	end

	always_comb begin
		krow_new = krow;
		vrow_new = vrow;
		for (int w = 0; w < WAYS; w++) begin
			if (ins && free_idx == WAY_W'(w)) begin
				krow_new[w*KE +: KE]       = {1'b1, key};
				vrow_new[w*VAL_W +: VAL_W] = value;
			end
			if (upd && hit_idx == WAY_W'(w)) begin
				vrow_new[w*VAL_W +: VAL_W] = value;
			end
			if (del && hit_idx == WAY_W'(w)) begin
				krow_new[w*KE + KEY_W] = 1'b0;
			end
		end
	end

endmodule

>>> hdl/hashed_key_value_table.sv
// Operation: an accepted word reads its bucket row straight away when BUCKETS is a power
// of two, else after the digit-by-digit key modulo in the bucket unit; the row is then
// compared, written back through the key and value RAMs, and the result registered. One
// word is handled at a time: the next is taken only after this single bucket read, compare
// and write-back. A result may wait in the output register while the next word is taken.
// Reset: a clearing pass writes a zero row to every bucket, zeroing every valid bit; input is stalled meanwhile.
// ----------------------------------------------------------------------------
// Hashed key-value table
// Map from 64-bit keys to 64-bit values in BUCKETS rows of WAYS ways; find,
// add or update, and delete, with a running entry count.
// ----------------------------------------------------------------------------
`include "hashed_key_value_table_defines.svh"

module hashed_key_value_table #(
	parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
	parameter int WAYS    = hkv_pkg::DEF_WAYS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hkv_pkg::FUNC_W-1:0]    func,
	input  logic [hkv_pkg::KEY_W-1:0]     key,
	input  logic [hkv_pkg::VAL_W-1:0]     value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [hkv_pkg::VAL_W-1:0]     value_out,
	output logic                          done_res,
	output logic                          full_res,
	output logic [hkv_pkg::TOTAL_W-1:0]   entry_total
);

	import hkv_pkg::*;

	localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam bit POW2  = ((BUCKETS & (BUCKETS - 1)) == 0);
	localparam int KE    = KEY_W + 1;
	localparam int KROW  = WAYS * KE;
	localparam int VROW  = WAYS * VAL_W;
	localparam int SLOTS = BUCKETS * WAYS;
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	// request held for the whole operation
	func_t              req_func_q;
	logic [KEY_W-1:0]   req_key_q;
	logic [VAL_W-1:0]   req_val_q;
	logic [BKT_W-1:0]   bucket_q;
	logic [BKT_W-1:0]   clr_cnt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;

	logic               accept;
	logic               issue;
	logic               exec_go;
	logic               clr;
	logic               clr_last;
	logic               out_free;

	logic               bkt_done;
	logic [BKT_W-1:0]   bkt_bucket;

	logic               kwe;
	logic [BKT_W-1:0]   kwaddr;
	logic [KROW-1:0]    kwdata;
	logic [KROW-1:0]    krow;
	logic [VROW-1:0]    vrow;
	logic [KROW-1:0]    krow_new;
	logic [VROW-1:0]    vrow_new;
	logic [VAL_W-1:0]   exec_val;
	res_t               res;
	logic [TOTAL_W-1:0] total_d;

	// output register
	logic               out_valid_q;
	logic               found_q;
	logic [VAL_W-1:0]   value_out_q;
	logic               done_q;
	logic               full_q;
	logic [TOTAL_W-1:0] total_q;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign clr_last = (clr_cnt_q == BKT_W'(BUCKETS - 1));

	// ---------------------------------------------------------------- control
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = POW2 ? ST_EXEC : ST_HASH;
			ST_HASH:  if (bkt_done) state_d = ST_EXEC;
			ST_EXEC:  if (out_free) state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		issue    = 1'b0;
		exec_go  = 1'b0;
		clr      = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				issue    = POW2 && in_valid;
			end
			ST_HASH:  issue = bkt_done;
			ST_EXEC:  exec_go = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (clr) begin
				clr_cnt_q <= clr_cnt_q + BKT_W'(1);
			end
			if (exec_go) begin
				cnt_q <= cnt_d;
			end
		end
	end

	// latch request; capture bucket when the row read goes out
	always_ff @(posedge clk) begin
		if (accept) begin
			req_func_q <= func_t'(func);
			req_key_q  <= key;
			req_val_q  <= value;
		end
		if (issue) begin
			bucket_q <= bkt_bucket;
		end
	end

	// ---------------------------------------------------------------- bucket
	hkv_bucket #(
		.BUCKETS (BUCKETS)
	) u_bucket (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key),
		.done   (bkt_done),
		.bucket (bkt_bucket)
	);

	// ---------------------------------------------------------------- storage
	// key RAM row: WAYS x {valid, key}; the clearing pass writes zero rows
	assign kwe    = clr || (exec_go && res.kwe);
	assign kwaddr = clr ? clr_cnt_q : bucket_q;
	assign kwdata = clr ? '0 : krow_new;

	hkv_ram #(
		.WIDTH (KROW),
		.DEPTH (BUCKETS)
	) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (kwaddr),
		.wdata (kwdata),
		.re    (issue),
		.raddr (bkt_bucket),
		.rdata (krow)
	);

	hkv_ram #(
		.WIDTH (VROW),
		.DEPTH (BUCKETS)
	) u_val_ram (
		.clk   (clk),
		.we    (exec_go && res.vwe),
		.waddr (bucket_q),
		.wdata (vrow_new),
		.re    (issue),
		.raddr (bkt_bucket),
		.rdata (vrow)
	);

	// ---------------------------------------------------------------- update
	hkv_exec #(
		.WAYS (WAYS)
	) u_exec (
		.func      (req_func_q),
		.key       (req_key_q),
		.value     (req_val_q),
		.krow      (krow),
		.vrow      (vrow),
		.krow_new  (krow_new),
		.vrow_new  (vrow_new),
		.value_out (exec_val),
		.res       (res)
	);

	// advance the count; hold it at zero on a delete that would wrap
	always_comb begin
		cnt_d = cnt_q;
		if (res.inc) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (res.dec && cnt_q != '0) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
	end

	generate
		if (CNT_W > TOTAL_W) begin : g_sat
			assign total_d = (cnt_d > CNT_W'(TOTAL_MAX)) ? TOTAL_MAX : cnt_d[TOTAL_W-1:0];
		end else begin : g_ext
			assign total_d = TOTAL_W'(cnt_d);
		end
	endgenerate

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			found_q     <= res.found;
			value_out_q <= exec_val;
			done_q      <= res.done;
			full_q      <= res.full;
			total_q     <= total_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign value_out   = value_out_q;
	assign done_res    = done_q;
	assign full_res    = full_q;
	assign entry_total = total_q;

	// ---------------------------------------------------------------- checks
	`HKV_ASSERT(a_kwe_window, kwe |-> (state_q == ST_CLEAR || exec_go), "key row write outside clear or update")
	`HKV_NEVER(a_done_full, exec_go && res.done && res.full, "insert reported both done and full")
	`HKV_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(SLOTS), "entry count beyond table size")
	`HKV_ASSERT(a_result_loaded, exec_go |=> (out_valid_q && state_q == ST_IDLE), "update did not load result")

endmodule
